// ===== hdl/mprq_pkg.sv =====
`timescale 1ns / 1ps
package mprq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // request modes
   localparam logic [1:0] MODE_PUSH  = 2'd0;
   localparam logic [1:0] MODE_POP   = 2'd1;
   localparam logic [1:0] MODE_OFFER = 2'd2;
   localparam logic [1:0] MODE_RSVD  = 2'd3;

   // disciplines
   localparam logic [2:0] DISC_FIFO    = 3'd0;
   localparam logic [2:0] DISC_PRIO    = 3'd1;
   localparam logic [2:0] DISC_PREEMPT = 3'd2;
   localparam logic [2:0] DISC_SJF     = 3'd3;
   localparam logic [2:0] DISC_FRONT   = 3'd4;
   localparam logic [2:0] DISC_WFQ     = 3'd5;

   // result status
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic        is_marker;
      logic [15:0] process_id;
      logic [7:0]  priority_req;
      logic [15:0] burst_length;
      logic [15:0] time_left;
      logic [7:0]  weight;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] popped_id;
      logic        popped_marker;
      logic        popped_was_preempted;
      logic        preempt_taken;
      logic [4:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  prio;
      logic [15:0] burst;
      logic [15:0] remaining;
      logic [7:0]  weight;
      logic        marker;
      logic        preempted;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [ADDR_W-1:0] rd_addr;
   } mem_ctl_type;

   // new record goes ahead of the stored one (sorted or front discipline)
   function automatic logic insert_before(input logic [2:0] disc, input req_type r,
                                          input entry_type e);
      logic hit;
      case (disc)
         DISC_PRIO, DISC_PREEMPT: hit = r.priority_req < e.prio;
         DISC_SJF:                hit = r.burst_length < e.burst;
         DISC_FRONT:              hit = 1'b1;
         default:                 hit = 1'b0;
      endcase
      return hit && !e.marker;
   endfunction

endpackage

// ===== hdl/multi_policy_ready_queue.sv =====
`timescale 1ns / 1ps
// Ready queue of up to 16 process records and termination markers held in one
// single-port-read entry memory, one word per request on each channel. A
// request is worked one at a time by a sequencer that reads an entry, waits
// for the registered data and evaluates it, once for every scanned or shifted
// entry. A push or accepted offer finds its place and moves the entries behind
// it back, a pop scans (one entry unless weighted fair) and moves the entries
// behind the removed one forward; an empty pop, full push, unknown mode or
// offer refused without a scan goes straight to the result, and an offer
// refused or dropped at the head is settled on the head entry. A new request
// is taken in the cycle after the previous word has gone to the output
// register. The discipline register is written through the csr port and
// must only change while the queue is idle.
module multi_policy_ready_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  mprq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mprq_pkg::rsp_type rsp_data
);
   import mprq_pkg::*;

   logic [2:0]  disc_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   logic        done_valid, done_ready;
   rsp_type     done_data;
   mem_ctl_type mem_ctl;
   entry_type   mem_wr_data, mem_rd_data;

   // discipline register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         disc_ff <= DISC_FIFO;
      end else if (csr_valid) begin
         disc_ff <= csr_data;
      end
   end

   mprq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .discipline  (disc_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done_data   (done_data),
      .mem_ctl     (mem_ctl),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   mprq_mem u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // output register
   assign done_ready = !rsp_valid_ff || rsp_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_ready) begin
         rsp_valid_ff <= done_valid;
      end
      if (done_ready && done_valid) begin
         rsp_data_ff <= done_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// ===== hdl/mprq_mem.sv =====
`timescale 1ns / 1ps
module mprq_mem (
   input  logic                clock,
   input  mprq_pkg::mem_ctl_type ctl,
   input  mprq_pkg::entry_type wr_data,
   output mprq_pkg::entry_type rd_data
);
   import mprq_pkg::*;

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[ctl.rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/mprq_ctrl.sv =====
`timescale 1ns / 1ps
module mprq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0]            discipline,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mprq_pkg::req_type     req_data,
   output logic                  done_valid,
   input  logic                  done_ready,
   output mprq_pkg::rsp_type     done_data,
   output mprq_pkg::mem_ctl_type mem_ctl,
   output mprq_pkg::entry_type   mem_wr_data,
   input  mprq_pkg::entry_type   mem_rd_data
);
   import mprq_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD   = 4'd1;
   localparam logic [3:0] S_EV   = 4'd2;
   localparam logic [3:0] S_SRD  = 4'd3;
   localparam logic [3:0] S_SWR  = 4'd4;
   localparam logic [3:0] S_WNEW = 4'd5;
   localparam logic [3:0] S_RRD  = 4'd6;
   localparam logic [3:0] S_RWR  = 4'd7;
   localparam logic [3:0] S_DONE = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] sel_ff, sel_in;
   req_type          item_ff, item_in;
   entry_type        best_ff, best_in;
   rsp_type          res_ff, res_in;

   logic [CNT_W-1:0] kp1, km1, pick_idx;
   logic [23:0]      lhs, rhs;
   logic             better, stop;
   entry_type        new_entry, pick;

   // entries behind the removed one still to move up (occ is the count before the pop)
   function automatic logic kp1_fits(input logic [CNT_W-1:0] idx,
                                     input logic [CNT_W-1:0] occ);
      return (idx + CNT_W'(1)) < occ;
   endfunction

   assign kp1 = k_ff + CNT_W'(1);
   assign km1 = k_ff - CNT_W'(1);

   // cross products for the weighted fair minimum
   assign lhs    = mem_rd_data.remaining * best_ff.weight;
   assign rhs    = best_ff.remaining * mem_rd_data.weight;
   assign better = (k_ff == '0) || (lhs < rhs);
   assign pick     = better ? mem_rd_data : best_ff;
   assign pick_idx = better ? k_ff : sel_ff;

   // entry stored by push or offer
   always_comb begin
      new_entry = '0;
      if (item_ff.is_marker && item_ff.mode == MODE_PUSH) begin
         new_entry.marker = 1'b1;
      end else begin
         new_entry.id        = item_ff.process_id;
         new_entry.prio      = item_ff.priority_req;
         new_entry.burst     = item_ff.burst_length;
         new_entry.remaining = item_ff.time_left;
         new_entry.weight    = (item_ff.weight == '0) ? 8'd1 : item_ff.weight;
         new_entry.preempted = item_ff.mode == MODE_OFFER;
      end
   end

   // sequencer: scan the entries, then shift them one word at a time
   always_comb begin
      state_in = state_ff;
      occ_in   = occ_ff;
      k_in     = k_ff;
      pos_in   = pos_ff;
      sel_in   = sel_ff;
      item_in  = item_ff;
      best_in  = best_ff;
      res_in   = res_ff;
      stop     = 1'b0;
      mem_ctl.wr_en   = 1'b0;
      mem_ctl.wr_addr = k_ff[ADDR_W-1:0];
      mem_ctl.rd_addr = k_ff[ADDR_W-1:0];
      mem_wr_data     = mem_rd_data;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               res_in  = '0;
               k_in    = '0;
               case (req_data.mode)
                  MODE_PUSH: begin
                     if (occ_ff >= CNT_W'(QUEUE_DEPTH)) begin
                        res_in.status = ST_FULL;
                        state_in      = S_DONE;
                     end else if (req_data.is_marker || occ_ff == '0) begin
                        pos_in   = '0;
                        k_in     = occ_ff;
                        state_in = (occ_ff == '0) ? S_WNEW : S_SRD;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  MODE_POP: begin
                     if (occ_ff == '0) begin
                        res_in.status = ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  MODE_OFFER: begin
                     if (discipline == DISC_PREEMPT && !req_data.is_marker &&
                         occ_ff != '0) begin
                        state_in = S_RD;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_RD: begin
            state_in = S_EV;
         end
         S_EV: begin
            if (item_ff.mode == MODE_POP) begin
               best_in = pick;
               sel_in  = pick_idx;
               if (k_ff == '0) begin
                  stop = discipline != DISC_WFQ || mem_rd_data.marker || kp1 == occ_ff;
               end else begin
                  stop = kp1 == occ_ff;
               end
               if (stop) begin
                  res_in.status               = ST_DONE;
                  res_in.popped_marker        = pick.marker;
                  res_in.popped_id            = pick.marker ? 16'd0 : pick.id;
                  res_in.popped_was_preempted = pick.marker ? 1'b0 : pick.preempted;
                  occ_in   = occ_ff - CNT_W'(1);
                  k_in     = pick_idx;
                  state_in = (kp1_fits(pick_idx, occ_ff)) ? S_RRD : S_DONE;
               end else begin
                  k_in     = kp1;
                  state_in = S_RD;
               end
            end else if (item_ff.mode == MODE_OFFER && k_ff == '0 &&
                         (mem_rd_data.marker ||
                          !(mem_rd_data.prio < item_ff.priority_req))) begin
               state_in = S_DONE;
            end else if (item_ff.mode == MODE_OFFER && k_ff == '0 &&
                         occ_ff >= CNT_W'(QUEUE_DEPTH)) begin
               res_in.status = ST_FULL;
               state_in      = S_DONE;
            end else if (insert_before(discipline, item_ff, mem_rd_data)) begin
               pos_in   = k_ff;
               k_in     = occ_ff;
               state_in = (occ_ff == k_ff) ? S_WNEW : S_SRD;
            end else if (kp1 == occ_ff) begin
               pos_in   = occ_ff;
               k_in     = occ_ff;
               state_in = S_WNEW;
            end else begin
               k_in     = kp1;
               state_in = S_RD;
            end
         end
         S_SRD: begin
            mem_ctl.rd_addr = km1[ADDR_W-1:0];
            state_in        = S_SWR;
         end
         S_SWR: begin
            mem_ctl.wr_en = 1'b1;
            k_in          = km1;
            state_in      = (km1 == pos_ff) ? S_WNEW : S_SRD;
         end
         S_WNEW: begin
            mem_ctl.wr_en        = 1'b1;
            mem_ctl.wr_addr      = pos_ff[ADDR_W-1:0];
            mem_wr_data          = new_entry;
            occ_in               = occ_ff + CNT_W'(1);
            res_in.status        = ST_DONE;
            res_in.preempt_taken = item_ff.mode == MODE_OFFER;
            state_in             = S_DONE;
         end
         S_RRD: begin
            mem_ctl.rd_addr = kp1[ADDR_W-1:0];
            state_in        = S_RWR;
         end
         S_RWR: begin
            mem_ctl.wr_en = 1'b1;
            k_in          = kp1;
            state_in      = (kp1 < occ_ff) ? S_RRD : S_DONE;
         end
         S_DONE: begin
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
      end
      k_ff    <= k_in;
      pos_ff  <= pos_in;
      sel_ff  <= sel_in;
      item_ff <= item_in;
      best_ff <= best_in;
      res_ff  <= res_in;
   end

   assign req_ready  = state_ff == S_IDLE;
   assign done_valid = state_ff == S_DONE;

   always_comb begin
      done_data             = res_ff;
      done_data.entry_count = 5'(occ_ff);
   end
endmodule

// ===== hdl/mprq_checker.sv =====
`timescale 1ns / 1ps
module mprq_assertions (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mprq_pkg::rsp_type rsp_data
);
   import mprq_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // failed items carry no popped record and no preemption
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_DONE |->
         rsp_data.popped_id == '0 && !rsp_data.popped_marker && !rsp_data.preempt_taken)
      else $error("failed item reports a result");

   // a marker pop carries no id
   a_marker_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.popped_marker |-> rsp_data.popped_id == '0 &&
         !rsp_data.popped_was_preempted && !rsp_data.preempt_taken)
      else $error("marker pop with record fields");

   // count never exceeds depth
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= 5'(QUEUE_DEPTH))
      else $error("entry count above depth");

   // no result right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind multi_policy_ready_queue mprq_assertions u_mprq_assertions (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== verif/mprq_checker.sv =====
`timescale 1ns / 1ps
module mprq_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [2:0]        csr_data,
   input  logic              req_valid,
   input  logic              req_ready,
   input  mprq_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  mprq_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_words,
   output int                word_total
);
   import mprq_pkg::*;

   typedef struct {
      logic [15:0] id;
      logic [7:0]  prio;
      logic [15:0] burst;
      logic [15:0] remaining;
      logic [7:0]  weight;
      logic        marker;
      logic        preempted;
   } slot_type;

   logic [2:0] disc_shadow;
   slot_type   queue_model[$];
   rsp_type    expected_words[$];

   // index of the first non-marker entry
   function automatic int first_record_pos();
      int k;
      k = 0;
      while (k < queue_model.size() && queue_model[k].marker) k++;
      return k;
   endfunction

   function automatic int sorted_pos(slot_type s, bit by_burst);
      int k;
      for (k = first_record_pos(); k < queue_model.size(); k++) begin
         if (by_burst ? (s.burst < queue_model[k].burst) : (s.prio < queue_model[k].prio))
            return k;
      end
      return queue_model.size();
   endfunction

   // next state and expected word for one accepted request
   function automatic rsp_type predict_queue(req_type r);
      rsp_type  w;
      slot_type s;
      int       sel;
      logic [31:0] lhs, rhs;
      w = '0;
      s.id = r.process_id; s.prio = r.priority_req; s.burst = r.burst_length;
      s.remaining = r.time_left;
      s.weight = (r.weight == 0) ? 8'd1 : r.weight;
      s.marker = 1'b0; s.preempted = 1'b0;
      if (r.mode == MODE_PUSH) begin
         if (queue_model.size() >= QUEUE_DEPTH) w.status = ST_FULL;
         else if (r.is_marker) begin
            s = '{default: '0};
            s.marker = 1'b1;
            queue_model.push_front(s);
         end else begin
            case (disc_shadow)
               DISC_PRIO, DISC_PREEMPT: queue_model.insert(sorted_pos(s, 0), s);
               DISC_SJF:   queue_model.insert(sorted_pos(s, 1), s);
               DISC_FRONT: queue_model.insert(first_record_pos(), s);
               default:    queue_model.push_back(s);
            endcase
         end
      end else if (r.mode == MODE_POP) begin
         if (queue_model.size() == 0) w.status = ST_EMPTY;
         else begin
            sel = 0;
            if (disc_shadow == DISC_WFQ && !queue_model[0].marker) begin
               for (int k = 1; k < queue_model.size(); k++) begin
                  lhs = 32'(queue_model[k].remaining) * 32'(queue_model[sel].weight);
                  rhs = 32'(queue_model[sel].remaining) * 32'(queue_model[k].weight);
                  if (lhs < rhs) sel = k;
               end
            end
            if (queue_model[sel].marker) w.popped_marker = 1'b1;
            else begin
               w.popped_id = queue_model[sel].id;
               w.popped_was_preempted = queue_model[sel].preempted;
            end
            queue_model.delete(sel);
         end
      end else if (r.mode == MODE_OFFER) begin
         if (disc_shadow == DISC_PREEMPT && !r.is_marker && queue_model.size() > 0 &&
             !queue_model[0].marker && queue_model[0].prio < r.priority_req) begin
            if (queue_model.size() >= QUEUE_DEPTH) w.status = ST_FULL;
            else begin
               s.preempted = 1'b1;
               queue_model.insert(sorted_pos(s, 0), s);
               w.preempt_taken = 1'b1;
            end
         end
      end
      w.entry_count = 5'(queue_model.size());
      return w;
   endfunction

   assign pending_words = expected_words.size();

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         disc_shadow <= DISC_FIFO;
         fail_count  <= 0;
         word_total  <= 0;
         queue_model.delete();
         expected_words.delete();
      end else begin
         if (csr_valid && csr_ready) disc_shadow <= csr_data;
         // compare outgoing word before queuing the new prediction
         if (rsp_valid && rsp_ready) begin
            word_total <= word_total + 1;
            if (expected_words.size() == 0) begin
               $error("unexpected word %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_words.pop_front();
               if (e != rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (e.status != rsp_data.status)
                     $error("status exp %0d got %0d", e.status, rsp_data.status);
                  if (e.popped_id != rsp_data.popped_id)
                     $error("popped_id exp %0d got %0d", e.popped_id, rsp_data.popped_id);
                  if (e.popped_marker != rsp_data.popped_marker)
                     $error("popped_marker exp %0d got %0d", e.popped_marker,
                            rsp_data.popped_marker);
                  if (e.popped_was_preempted != rsp_data.popped_was_preempted)
                     $error("popped_was_preempted exp %0d got %0d",
                            e.popped_was_preempted, rsp_data.popped_was_preempted);
                  if (e.preempt_taken != rsp_data.preempt_taken)
                     $error("preempt_taken exp %0d got %0d", e.preempt_taken,
                            rsp_data.preempt_taken);
                  if (e.entry_count != rsp_data.entry_count)
                     $error("entry_count exp %0d got %0d", e.entry_count,
                            rsp_data.entry_count);
               end
            end
         end
         if (req_valid && req_ready) expected_words.push_back(predict_queue(req_data));
      end
   end
endmodule

// ===== verif/tb_multi_policy_ready_queue.sv =====
`timescale 1ns / 1ps
module tb_multi_policy_ready_queue;
   import mprq_pkg::*;

   logic    clock, reset;
   logic    csr_valid, csr_ready;
   logic [2:0] csr_data;
   logic    req_valid, req_ready;
   req_type req_data;
   logic    rsp_valid, rsp_ready;
   rsp_type rsp_data;
   int      fail_count, pending_words, word_total;
   int      sent_words;
   logic    stall_mode;

   multi_policy_ready_queue i_dut (
      .clock, .reset, .csr_valid, .csr_ready, .csr_data,
      .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready, .rsp_data
   );

   mprq_checker i_checker (
      .clock, .reset, .csr_valid, .csr_ready, .csr_data,
      .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready, .rsp_data,
      .fail_count, .pending_words, .word_total
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stall pattern: alternates calm stretches and heavy stalling
   initial begin
      rsp_ready  = 1'b0;
      stall_mode = 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
         rsp_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
      end
   end

   function automatic req_type rand_word(int pop_bias);
      req_type r;
      int      pick;
      r.process_id   = 16'($urandom);
      r.priority_req = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      r.burst_length = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
      r.time_left    = 16'($urandom);
      r.weight       = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
      r.is_marker    = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 2) r.mode = MODE_RSVD;
      else if (pick < pop_bias) r.mode = MODE_POP;
      else if (pick < pop_bias + 20) r.mode = MODE_OFFER;
      else r.mode = MODE_PUSH;
      return r;
   endfunction

   task automatic send_word(req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_words++;
   endtask

   task automatic make_word(logic [1:0] m, logic mk, logic [15:0] id, logic [7:0] pr,
                            logic [15:0] bu, logic [15:0] re, logic [7:0] we);
      req_type r;
      r = '{mode: m, is_marker: mk, process_id: id, priority_req: pr, burst_length: bu,
            time_left: re, weight: we};
      send_word(r);
   endtask

   task automatic drain_and_set(logic [2:0] d);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int burst_len;
      int gap;
      logic [2:0] disc_list[8];
      disc_list = '{DISC_FIFO, DISC_PRIO, DISC_PREEMPT, DISC_SJF, DISC_FRONT, DISC_WFQ,
                    3'd6, 3'd7};
      sent_words = 0;
      reset = 1'b1; csr_valid = 1'b0; csr_data = '0; req_valid = 1'b0; req_data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop, markers, sorted inserts, preemption, wfq, fill to full
      drain_and_set(DISC_PREEMPT);
      make_word(MODE_POP, 0, 0, 0, 0, 0, 0);
      make_word(MODE_OFFER, 0, 16'h1111, 8'd9, 0, 0, 0);
      make_word(MODE_PUSH, 0, 16'hFFFF, 8'd5, 16'hFFFF, 16'hFFFF, 8'hFF);
      make_word(MODE_PUSH, 0, 16'h0002, 8'd0, 16'h0000, 16'h0000, 8'h00);
      make_word(MODE_OFFER, 0, 16'h0003, 8'd255, 0, 0, 0);
      make_word(MODE_OFFER, 1, 16'h0004, 8'd255, 0, 0, 0);
      make_word(MODE_OFFER, 0, 16'h0005, 8'd0, 0, 0, 0);
      make_word(MODE_PUSH, 1, 16'hAAAA, 8'd1, 0, 0, 0);
      make_word(MODE_OFFER, 0, 16'h0006, 8'd200, 0, 0, 0);
      make_word(MODE_RSVD, 1, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      repeat (5) make_word(MODE_POP, 0, 0, 0, 0, 0, 0);
      drain_and_set(DISC_WFQ);
      make_word(MODE_PUSH, 0, 16'h0010, 8'd1, 16'd1, 16'd100, 8'd0);
      make_word(MODE_PUSH, 0, 16'h0011, 8'd1, 16'd1, 16'd300, 8'd3);
      make_word(MODE_PUSH, 0, 16'h0012, 8'd1, 16'd1, 16'hFFFF, 8'd255);
      make_word(MODE_PUSH, 1, 0, 0, 0, 0, 0);
      repeat (5) make_word(MODE_POP, 0, 0, 0, 0, 0, 0);
      repeat (17) make_word(MODE_PUSH, 0, 16'(sent_words), 8'd3, 16'd4, 16'd5, 8'd1);
      drain_and_set(DISC_PREEMPT);
      make_word(MODE_OFFER, 0, 16'h0BAD, 8'd9, 0, 0, 0);

      // random bursts; each phase picks a discipline, extremes included
      for (int phase = 0; phase < 16; phase++) begin
         drain_and_set(phase < 8 ? disc_list[phase] : 3'($urandom_range(0, 7)));
         for (int n = 0; n < 45; ) begin
            burst_len = $urandom_range(1, 12);
            for (int b = 0; b < burst_len; b++) begin
               send_word(rand_word(phase[0] ? 45 : 30));
               n++;
            end
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("sent %0d request words over all disciplines, checked %0d response words",
               sent_words, word_total);
      if (fail_count == 0 && pending_words == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end
endmodule
